// ===== design/xxh_pkg.sv =====
// shared types, constants and helpers for the xxh64 stream hash
// no dependencies

package xxh_pkg;

   localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] P3 = 64'h165667B19E3779F9;
   localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

   typedef enum logic [5:0] {
      S_IDLE, S_BYTES, S_WAIT,
      S_R1, S_R2,
      S_FIN, S_M1, S_M2, S_M3, S_HLEN,
      S_TAIL, S_E1, S_E2, S_E3, S_F1, S_F2, S_B1, S_B2,
      S_A1, S_A2, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_BYTE, OP_HMERGE, OP_HP5, OP_HLEN,
      OP_POS8, OP_POS4, OP_POS1, OP_DONE
   } op_type;

   typedef enum logic [3:0] {
      A_LANE, A_ACC, A_ACC_T, A_T31, A_HT, A_HT27, A_HT23, A_HT11,
      A_LANE4, A_BYTE, A_AV33, A_AV29
   } asel_type;

   typedef enum logic [2:0] {
      B_P1, B_P2, B_P3, B_P5
   } bsel_type;

   typedef enum logic [1:0] {
      D_T, D_ACC, D_H
   } dst_type;

   typedef enum logic [1:0] {
      K_NONE, K_P3, K_P4
   } addk_type;

   typedef struct packed {
      op_type     op;
      logic       mstart;
      asel_type   a_sel;
      bsel_type   b_sel;
      dst_type    dst;
      addk_type   addk;
      logic [1:0] idx;
      logic       use_pos;
   } cmd_type;

   typedef struct packed {
      logic more_bytes;
      logic fill_full;
      logic last;
      logic is_short;
      logic rem_ge8;
      logic rem_ge4;
      logic rem_nz;
      logic mul_done;
      logic rsp_full;
   } status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
      return (v << r) | (v >> (64 - r));
   endfunction

endpackage

// ===== design/xxh_mul.sv =====
// 64x64 low-half multiplier built from three 32x32 partial products
// uses no package

module xxh_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] p
);

   logic [63:0] a_ff, a_in, b_ff, b_in, prod_ff, prod_in;
   logic [1:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [63:0] pp;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      step_in = step_ff;
      done_in = 1'b0;
      pp      = '0;
      case (step_ff)
         2'd1: begin
            pp      = a_ff[31:0] * b_ff[31:0];
            prod_in = pp;
            step_in = 2'd2;
         end
         2'd2: begin
            pp      = a_ff[31:0] * b_ff[63:32];
            prod_in = prod_ff + {pp[31:0], 32'b0};
            step_in = 2'd3;
         end
         2'd3: begin
            pp      = a_ff[63:32] * b_ff[31:0];
            prod_in = prod_ff + {pp[31:0], 32'b0};
            step_in = 2'd0;
            done_in = 1'b1;
         end
         default: begin
            if (start) begin
               a_in    = a;
               b_in    = b;
               step_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign p    = prod_ff;

endmodule

// ===== design/xxh_dp.sv =====
// datapath: stripe buffer, lane accumulators, length, hash and result register
// depends on xxh_pkg and xxh_mul

module xxh_dp (
   input  logic                clock,
   input  logic                reset,
   input  xxh_pkg::cmd_type    cmd,
   output xxh_pkg::status_type status,
   input  logic [63:0]         req_data_word,
   input  logic [3:0]          req_byte_count,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_digest
);

   logic [63:0] acc_ff [4];
   logic [63:0] acc_in [4];
   logic [63:0] buf_ff [4];
   logic [63:0] buf_in [4];
   logic [4:0]  fill_ff, fill_in, pos_ff, pos_in, rem_ff, rem_in;
   logic [63:0] len_ff, len_in, h_ff, h_in, t_ff, t_in, data_ff, data_in;
   logic [3:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic        last_ff, last_in, rv_ff, rv_in;
   logic [63:0] dig_ff, dig_in;
   xxh_pkg::dst_type  dst_ff, dst_in;
   xxh_pkg::addk_type addk_ff, addk_in;
   logic [1:0]  didx_ff, didx_in;

   logic [63:0] ma, mb, mp, lane, wb;
   logic        mdone;
   logic [31:0] half;
   logic [7:0]  pbyte;

   xxh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mstart),
      .a     (ma),
      .b     (mb),
      .done  (mdone),
      .p     (mp)
   );

   always_comb begin
      lane  = buf_ff[cmd.use_pos ? pos_ff[4:3] : cmd.idx];
      half  = pos_ff[2] ? lane[63:32] : lane[31:0];
      pbyte = 8'(lane >> {pos_ff[2:0], 3'b000});
      case (cmd.a_sel)
         xxh_pkg::A_LANE:  ma = lane;
         xxh_pkg::A_ACC:   ma = acc_ff[cmd.idx];
         xxh_pkg::A_ACC_T: ma = xxh_pkg::rotl64(acc_ff[cmd.idx] + t_ff, 31);
         xxh_pkg::A_T31:   ma = xxh_pkg::rotl64(t_ff, 31);
         xxh_pkg::A_HT:    ma = h_ff ^ t_ff;
         xxh_pkg::A_HT27:  ma = xxh_pkg::rotl64(h_ff ^ t_ff, 27);
         xxh_pkg::A_HT23:  ma = xxh_pkg::rotl64(h_ff ^ t_ff, 23);
         xxh_pkg::A_HT11:  ma = xxh_pkg::rotl64(h_ff ^ t_ff, 11);
         xxh_pkg::A_LANE4: ma = {32'b0, half};
         xxh_pkg::A_BYTE:  ma = {56'b0, pbyte};
         xxh_pkg::A_AV33:  ma = h_ff ^ (h_ff >> 33);
         xxh_pkg::A_AV29:  ma = h_ff ^ (h_ff >> 29);
         default:          ma = '0;
      endcase
      case (cmd.b_sel)
         xxh_pkg::B_P1: mb = xxh_pkg::P1;
         xxh_pkg::B_P2: mb = xxh_pkg::P2;
         xxh_pkg::B_P3: mb = xxh_pkg::P3;
         xxh_pkg::B_P5: mb = xxh_pkg::P5;
         default:       mb = '0;
      endcase
      case (addk_ff)
         xxh_pkg::K_P3: wb = mp + xxh_pkg::P3;
         xxh_pkg::K_P4: wb = mp + xxh_pkg::P4;
         default:       wb = mp;
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      buf_in  = buf_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      h_in    = h_ff;
      t_in    = t_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      last_in = last_ff;
      dig_in  = dig_ff;
      dst_in  = dst_ff;
      addk_in = addk_ff;
      didx_in = didx_ff;
      rv_in   = rv_ff && rsp_stall;

      if (cmd.mstart) begin
         dst_in  = cmd.dst;
         addk_in = cmd.addk;
         didx_in = cmd.idx;
      end
      if (mdone) begin
         case (dst_ff)
            xxh_pkg::D_T:   t_in = wb;
            xxh_pkg::D_ACC: acc_in[didx_ff] = wb;
            default:        h_in = wb;
         endcase
      end

      case (cmd.op)
         xxh_pkg::OP_LOAD: begin
            data_in = req_data_word;
            cnt_in  = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
            k_in    = '0;
            last_in = req_last_item;
         end
         xxh_pkg::OP_BYTE: begin
            for (int w = 0; w < 4; w++) begin
               for (int b = 0; b < 8; b++) begin
                  if (fill_ff[4:3] == 2'(w) && fill_ff[2:0] == 3'(b)) begin
                     buf_in[w][8*b +: 8] = 8'(data_ff >> {k_ff[2:0], 3'b000});
                  end
               end
            end
            fill_in = fill_ff + 5'd1;
            len_in  = len_ff + 64'd1;
            k_in    = k_ff + 4'd1;
         end
         xxh_pkg::OP_HMERGE: begin
            h_in = xxh_pkg::rotl64(acc_ff[0], 1) + xxh_pkg::rotl64(acc_ff[1], 7)
                 + xxh_pkg::rotl64(acc_ff[2], 12) + xxh_pkg::rotl64(acc_ff[3], 18);
         end
         xxh_pkg::OP_HP5: h_in = xxh_pkg::P5;
         xxh_pkg::OP_HLEN: begin
            h_in   = h_ff + len_ff;
            rem_in = fill_ff;
            pos_in = '0;
         end
         xxh_pkg::OP_POS8: begin
            pos_in = pos_ff + 5'd8;
            rem_in = rem_ff - 5'd8;
         end
         xxh_pkg::OP_POS4: begin
            pos_in = pos_ff + 5'd4;
            rem_in = rem_ff - 5'd4;
         end
         xxh_pkg::OP_POS1: begin
            pos_in = pos_ff + 5'd1;
            rem_in = rem_ff - 5'd1;
         end
         xxh_pkg::OP_DONE: begin
            dig_in    = h_ff ^ (h_ff >> 32);
            rv_in     = 1'b1;
            acc_in[0] = xxh_pkg::P1 + xxh_pkg::P2;
            acc_in[1] = xxh_pkg::P2;
            acc_in[2] = '0;
            acc_in[3] = 64'd0 - xxh_pkg::P1;
            fill_in   = '0;
            len_in    = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= xxh_pkg::P1 + xxh_pkg::P2;
         acc_ff[1] <= xxh_pkg::P2;
         acc_ff[2] <= '0;
         acc_ff[3] <= 64'd0 - xxh_pkg::P1;
         fill_ff   <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         k_ff      <= '0;
         rv_ff     <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
         k_ff    <= k_in;
         rv_ff   <= rv_in;
      end
      buf_ff  <= buf_in;
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      h_ff    <= h_in;
      t_ff    <= t_in;
      data_ff <= data_in;
      last_ff <= last_in;
      dig_ff  <= dig_in;
      dst_ff  <= dst_in;
      addk_ff <= addk_in;
      didx_ff <= didx_in;
   end

   always_comb begin
      status.more_bytes = k_ff < cnt_ff;
      status.fill_full  = fill_ff == 5'd31;
      status.last       = last_ff;
      status.is_short   = len_ff[63:5] == '0;
      status.rem_ge8    = rem_ff >= 5'd8;
      status.rem_ge4    = rem_ff >= 5'd4;
      status.rem_nz     = rem_ff != '0;
      status.mul_done   = mdone;
      status.rsp_full   = rv_ff && rsp_stall;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_digest = dig_ff;

endmodule

// ===== design/xxh_ctrl.sv =====
// controller: sequences byte intake, stripe rounds, tail merge and avalanche
// depends on xxh_pkg

module xxh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output xxh_pkg::cmd_type    cmd,
   input  xxh_pkg::status_type status
);

   xxh_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xxh_pkg::S_IDLE;
         ret_ff   <= xxh_pkg::S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      idx_in      = idx_ff;
      req_stall   = 1'b1;
      cmd.op      = xxh_pkg::OP_NONE;
      cmd.mstart  = 1'b0;
      cmd.a_sel   = xxh_pkg::A_LANE;
      cmd.b_sel   = xxh_pkg::B_P1;
      cmd.dst     = xxh_pkg::D_T;
      cmd.addk    = xxh_pkg::K_NONE;
      cmd.idx     = idx_ff;
      cmd.use_pos = 1'b0;
      case (state_ff)
         xxh_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = xxh_pkg::OP_LOAD;
               state_in = xxh_pkg::S_BYTES;
            end
         end
         xxh_pkg::S_BYTES: begin
            if (status.more_bytes) begin
               cmd.op = xxh_pkg::OP_BYTE;
               if (status.fill_full) state_in = xxh_pkg::S_R1;
            end else if (status.last) begin
               state_in = xxh_pkg::S_FIN;
            end else begin
               state_in = xxh_pkg::S_IDLE;
            end
         end
         xxh_pkg::S_WAIT: begin
            if (status.mul_done) state_in = ret_ff;
         end
         xxh_pkg::S_R1: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_LANE;
            cmd.b_sel  = xxh_pkg::B_P2;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_R2;
         end
         xxh_pkg::S_R2: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_ACC_T;
            cmd.dst    = xxh_pkg::D_ACC;
            idx_in     = idx_ff + 2'd1;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = (idx_ff == 2'd3) ? xxh_pkg::S_BYTES : xxh_pkg::S_R1;
         end
         xxh_pkg::S_FIN: begin
            if (status.is_short) begin
               cmd.op   = xxh_pkg::OP_HP5;
               state_in = xxh_pkg::S_HLEN;
            end else begin
               cmd.op   = xxh_pkg::OP_HMERGE;
               state_in = xxh_pkg::S_M1;
            end
         end
         xxh_pkg::S_M1: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_ACC;
            cmd.b_sel  = xxh_pkg::B_P2;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_M2;
         end
         xxh_pkg::S_M2: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_T31;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_M3;
         end
         xxh_pkg::S_M3: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_HT;
            cmd.dst    = xxh_pkg::D_H;
            cmd.addk   = xxh_pkg::K_P4;
            idx_in     = idx_ff + 2'd1;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = (idx_ff == 2'd3) ? xxh_pkg::S_HLEN : xxh_pkg::S_M1;
         end
         xxh_pkg::S_HLEN: begin
            cmd.op   = xxh_pkg::OP_HLEN;
            state_in = xxh_pkg::S_TAIL;
         end
         xxh_pkg::S_TAIL: begin
            if (status.rem_ge8)      state_in = xxh_pkg::S_E1;
            else if (status.rem_ge4) state_in = xxh_pkg::S_F1;
            else if (status.rem_nz)  state_in = xxh_pkg::S_B1;
            else                     state_in = xxh_pkg::S_A1;
         end
         xxh_pkg::S_E1: begin
            cmd.mstart  = 1'b1;
            cmd.a_sel   = xxh_pkg::A_LANE;
            cmd.b_sel   = xxh_pkg::B_P2;
            cmd.use_pos = 1'b1;
            state_in    = xxh_pkg::S_WAIT;
            ret_in      = xxh_pkg::S_E2;
         end
         xxh_pkg::S_E2: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_T31;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_E3;
         end
         xxh_pkg::S_E3: begin
            cmd.mstart = 1'b1;
            cmd.op     = xxh_pkg::OP_POS8;
            cmd.a_sel  = xxh_pkg::A_HT27;
            cmd.dst    = xxh_pkg::D_H;
            cmd.addk   = xxh_pkg::K_P4;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_TAIL;
         end
         xxh_pkg::S_F1: begin
            cmd.mstart  = 1'b1;
            cmd.a_sel   = xxh_pkg::A_LANE4;
            cmd.use_pos = 1'b1;
            state_in    = xxh_pkg::S_WAIT;
            ret_in      = xxh_pkg::S_F2;
         end
         xxh_pkg::S_F2: begin
            cmd.mstart = 1'b1;
            cmd.op     = xxh_pkg::OP_POS4;
            cmd.a_sel  = xxh_pkg::A_HT23;
            cmd.b_sel  = xxh_pkg::B_P2;
            cmd.dst    = xxh_pkg::D_H;
            cmd.addk   = xxh_pkg::K_P3;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_TAIL;
         end
         xxh_pkg::S_B1: begin
            cmd.mstart  = 1'b1;
            cmd.a_sel   = xxh_pkg::A_BYTE;
            cmd.b_sel   = xxh_pkg::B_P5;
            cmd.use_pos = 1'b1;
            state_in    = xxh_pkg::S_WAIT;
            ret_in      = xxh_pkg::S_B2;
         end
         xxh_pkg::S_B2: begin
            cmd.mstart = 1'b1;
            cmd.op     = xxh_pkg::OP_POS1;
            cmd.a_sel  = xxh_pkg::A_HT11;
            cmd.dst    = xxh_pkg::D_H;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_TAIL;
         end
         xxh_pkg::S_A1: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_AV33;
            cmd.b_sel  = xxh_pkg::B_P2;
            cmd.dst    = xxh_pkg::D_H;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_A2;
         end
         xxh_pkg::S_A2: begin
            cmd.mstart = 1'b1;
            cmd.a_sel  = xxh_pkg::A_AV29;
            cmd.b_sel  = xxh_pkg::B_P3;
            cmd.dst    = xxh_pkg::D_H;
            state_in   = xxh_pkg::S_WAIT;
            ret_in     = xxh_pkg::S_DONE;
         end
         xxh_pkg::S_DONE: begin
            if (!status.rsp_full) begin
               cmd.op   = xxh_pkg::OP_DONE;
               idx_in   = '0;
               state_in = xxh_pkg::S_IDLE;
            end
         end
         default: state_in = xxh_pkg::S_IDLE;
      endcase
   end

   a_no_start_in_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == xxh_pkg::S_WAIT |-> !cmd.mstart)
      else $error("multiply started while one is in flight");

   a_done_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> state_ff == xxh_pkg::S_WAIT)
      else $error("multiply result arrived outside wait");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> state_ff == xxh_pkg::S_IDLE)
      else $error("word accepted while busy");

   a_idx_zero_at_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == xxh_pkg::S_IDLE |-> idx_ff == 2'd0)
      else $error("lane index not cleared at idle");

endmodule

// ===== design/xxh64_stream_hash.sv =====
// top level of the xxh64 (seed zero) stream hash
// depends on xxh_pkg, xxh_ctrl, xxh_dp and xxh_mul
//
// channel  ports                                    direction
// req      req_valid/req_stall, data_word,          in
//          byte_count, last_item
// rsp      rsp_valid/rsp_stall, digest               out
//
// each word's bytes are taken in one byte per cycle, except while a full stripe's rounds run
// a full stripe adds 4 lanes x 2 multiplies, issued one at a time to the
//   shared multiplier, which forms three 32x32 partial products per multiply
// the final word adds merge (long messages only), tail and avalanche steps
// reset loads the lane accumulators with their seed values and clears fill and length; no clearing pass
// a held digest does not block intake of the next message's words

module xxh64_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest
);

   // command and status between sequencer and datapath
   xxh_pkg::cmd_type    cmd;
   xxh_pkg::status_type status;

   xxh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath holds the result register, so the digest waits there
   xxh_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digest     (rsp_digest)
   );

endmodule
